// ===== hw/rtl/pixel_format_converter_macros.svh =====
// Assertion helpers for the pixel format converter.
`ifndef PIXEL_FORMAT_CONVERTER_MACROS_SVH
`define PIXEL_FORMAT_CONVERTER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked while out of reset.
`define PFC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pixel_format_converter: check failed");
// Next-cycle implication, checked while out of reset.
`define PFC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pixel_format_converter: check failed");
`else
`define PFC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PFC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/pfc_pkg.sv =====
package pfc_pkg;

    localparam int unsigned FMT_WIDTH       = 3;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 8;

    // Format codes
    localparam logic [FMT_WIDTH-1:0] FMT_RGBA8888 = 3'd0;
    localparam logic [FMT_WIDTH-1:0] FMT_RGB888   = 3'd1;
    localparam logic [FMT_WIDTH-1:0] FMT_ARGB1555 = 3'd2;
    localparam logic [FMT_WIDTH-1:0] FMT_RGB565   = 3'd3;
    localparam logic [FMT_WIDTH-1:0] FMT_BGR888   = 3'd4;
    localparam logic [FMT_WIDTH-1:0] FMT_BGRA8888 = 3'd5;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET_FORMAT = 2'd1;

    // Byte counts
    localparam logic [2:0] BYTES_NONE = 3'd0;
    localparam logic [2:0] BYTES_TWO  = 3'd2;
    localparam logic [2:0] BYTES_THREE = 3'd3;
    localparam logic [2:0] BYTES_FOUR = 3'd4;

    typedef struct packed {
        logic [31:0] pixel_in;
        logic        last_in;
    } pfc_in_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic [2:0]  byte_count;
        logic        unsupported;
        logic        last_out;
    } pfc_out_t;

endpackage

// ===== hw/rtl/pixel_format_converter.sv =====
// Pixel format converter: takes one pixel per request on the s_ channel and returns one
// converted pixel per request on the m_ channel, in order, at one pixel per clock while
// m_ready allows it. A pixel passes an input register, then the bit rearrangement selected
// by source_format and target_format, then the result register that drives m_valid and
// m_data; both registers sit behind a ready chain, so a stall on m_ready holds the pipe
// without losing a request. Pixels are little-endian, byte 0 in bits 7:0. Format codes:
// 0 RGBA8888, 1 RGB888, 2 ARGB1555, 3 RGB565, 4 BGR888, 5 BGRA8888. A pair with no
// converter (every BGRA8888 target, codes 6 and 7, and the remaining gaps of the table)
// returns pixel_out 0, byte_count 0 and unsupported 1; last_out always copies last_in.
// Registers: index 0 source_format, index 1 target_format, low 3 bits of cfg_data kept,
// other indexes ignored; cfg_ready is always high. Write them only while the pipe is empty.
`include "pixel_format_converter_macros.svh"

module pixel_format_converter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pfc_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pfc_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
    // Pixel input channel
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  pfc_pkg::pfc_in_t                       s_data,
    // Converted pixel channel
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output pfc_pkg::pfc_out_t                      m_data
);
    import pfc_pkg::*;

    logic [FMT_WIDTH-1:0] source_format_reg;
    logic [FMT_WIDTH-1:0] target_format_reg;

    logic     in_valid_reg;
    pfc_in_t  in_data_reg;
    logic     out_valid_reg;
    pfc_out_t out_data_reg;
    pfc_out_t out_data_next;

    logic out_free;
    logic in_advance;

    // Configuration registers: always ready, drop writes to unknown indexes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= FMT_RGBA8888;
            target_format_reg <= FMT_RGBA8888;
        end else if (cfg_valid) begin
            if (cfg_index == REG_SOURCE_FORMAT) begin
                source_format_reg <= cfg_data[FMT_WIDTH-1:0];
            end else if (cfg_index == REG_TARGET_FORMAT) begin
                target_format_reg <= cfg_data[FMT_WIDTH-1:0];
            end
        end
    end

    // Ready chain: the result register frees when empty or drained this cycle; the input
    // register frees when empty or when its request advances.
    assign out_free   = !out_valid_reg || m_ready;
    assign in_advance = in_valid_reg && out_free;
    assign s_ready    = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Conversion: pure bit rearrangement of the registered pixel.
    always_comb begin
        logic [31:0] p;
        logic [15:0] c;
        logic [7:0]  b0, b1, b2, b3;
        logic [7:0]  r5, g5, b5;
        logic [7:0]  r6, g6, b6;
        logic        ok;

        p  = in_data_reg.pixel_in;
        c  = p[15:0];
        b0 = p[7:0];
        b1 = p[15:8];
        b2 = p[23:16];
        b3 = p[31:24];
        // ARGB1555 fields shifted up, no replication
        r5 = {c[14:10], 3'b000};
        g5 = {c[9:5], 3'b000};
        b5 = {c[4:0], 3'b000};
        // RGB565 fields shifted up, no replication
        r6 = {c[15:11], 3'b000};
        g6 = {c[10:5], 2'b00};
        b6 = {c[4:0], 3'b000};

        ok                        = 1'b1;
        out_data_next.pixel_out   = '0;
        out_data_next.byte_count  = BYTES_NONE;
        out_data_next.unsupported = 1'b0;
        out_data_next.last_out    = in_data_reg.last_in;

        unique case (source_format_reg)
            FMT_RGBA8888: begin
                if (target_format_reg == FMT_RGBA8888) begin
                    out_data_next.pixel_out  = p;
                    out_data_next.byte_count = BYTES_FOUR;
                end else if (target_format_reg == FMT_RGB888) begin
                    out_data_next.pixel_out  = {8'h00, b2, b1, b0};
                    out_data_next.byte_count = BYTES_THREE;
                end else if (target_format_reg == FMT_BGR888) begin
                    out_data_next.pixel_out  = {8'h00, b0, b1, b2};
                    out_data_next.byte_count = BYTES_THREE;
                end else begin
                    ok = 1'b0;
                end
            end
            FMT_RGB888: begin
                if (target_format_reg == FMT_RGBA8888) begin
                    out_data_next.pixel_out  = {8'hFF, b2, b1, b0};
                    out_data_next.byte_count = BYTES_FOUR;
                end else if (target_format_reg == FMT_RGB888) begin
                    out_data_next.pixel_out  = {8'h00, b2, b1, b0};
                    out_data_next.byte_count = BYTES_THREE;
                end else if (target_format_reg == FMT_BGR888) begin
                    out_data_next.pixel_out  = {8'h00, b0, b1, b2};
                    out_data_next.byte_count = BYTES_THREE;
                end else begin
                    ok = 1'b0;
                end
            end
            FMT_ARGB1555: begin
                if (target_format_reg == FMT_RGBA8888) begin
                    // Replicate the top bits into the low bits of each channel.
                    out_data_next.pixel_out  = {{8{c[15]}},
                                                c[14:10], c[14:12],
                                                c[9:5], c[9:7],
                                                c[4:0], c[4:2]};
                    out_data_next.byte_count = BYTES_FOUR;
                end else if (target_format_reg == FMT_RGB888) begin
                    out_data_next.pixel_out  = {8'h00, r5, g5, b5};
                    out_data_next.byte_count = BYTES_THREE;
                end else if (target_format_reg == FMT_ARGB1555) begin
                    out_data_next.pixel_out  = {16'h0000, c};
                    out_data_next.byte_count = BYTES_TWO;
                end else if (target_format_reg == FMT_BGR888) begin
                    out_data_next.pixel_out  = {8'h00, b5, g5, r5};
                    out_data_next.byte_count = BYTES_THREE;
                end else begin
                    ok = 1'b0;
                end
            end
            FMT_RGB565: begin
                if (target_format_reg == FMT_RGB888) begin
                    out_data_next.pixel_out  = {8'h00, r6, g6, b6};
                    out_data_next.byte_count = BYTES_THREE;
                end else if (target_format_reg == FMT_ARGB1555) begin
                    // Set alpha, drop the low green bit.
                    out_data_next.pixel_out  = {16'h0000, 1'b1, c[15:6], c[4:0]};
                    out_data_next.byte_count = BYTES_TWO;
                end else if (target_format_reg == FMT_BGR888) begin
                    out_data_next.pixel_out  = {8'h00, b6, g6, r6};
                    out_data_next.byte_count = BYTES_THREE;
                end else begin
                    ok = 1'b0;
                end
            end
            FMT_BGR888: begin
                if (target_format_reg == FMT_RGBA8888) begin
                    out_data_next.pixel_out  = {8'hFF, b0, b1, b2};
                    out_data_next.byte_count = BYTES_FOUR;
                end else if (target_format_reg == FMT_RGB888) begin
                    out_data_next.pixel_out  = {8'h00, b0, b1, b2};
                    out_data_next.byte_count = BYTES_THREE;
                end else begin
                    ok = 1'b0;
                end
            end
            FMT_BGRA8888: begin
                if (target_format_reg == FMT_RGBA8888) begin
                    out_data_next.pixel_out  = {b3, b0, b1, b2};
                    out_data_next.byte_count = BYTES_FOUR;
                end else begin
                    ok = 1'b0;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        // Zero the pixel and count on an unsupported pair.
        if (!ok) begin
            out_data_next.pixel_out   = '0;
            out_data_next.byte_count  = BYTES_NONE;
            out_data_next.unsupported = 1'b1;
        end
    end

    // Result register: load when the input register advances, hold while stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // An unsupported result carries no pixel bytes.
    `PFC_ASSERT_IMP(a_unsupported_zero, aclk, aresetn,
        out_valid_reg && out_data_reg.unsupported,
        out_data_reg.pixel_out == 32'h0 && out_data_reg.byte_count == BYTES_NONE)
    // A supported result always has a nonzero byte count.
    `PFC_ASSERT_IMP(a_supported_count, aclk, aresetn,
        out_valid_reg && !out_data_reg.unsupported,
        out_data_reg.byte_count != BYTES_NONE)
    // A request waiting in the input register with an empty result register moves on.
    `PFC_ASSERT_NXT(a_pipe_advance, aclk, aresetn,
        in_valid_reg && !out_valid_reg,
        out_valid_reg)

endmodule
